/* src/brf_pkg.sv */
// Shared types and constants of the bisection root finder.
// No dependencies; every other file of the block refers to it by scoped names.
package brf_pkg;

    localparam int WORD_BITS    = 32;
    localparam int FRAC_BITS    = 16;
    localparam int CNT_BITS     = 7;
    localparam int TOL_BITS     = 31;
    localparam int CFG_IDX_BITS = 3;
    localparam int STEP_BITS    = 3;
    localparam int PROD_BITS    = 2 * WORD_BITS;
    localparam int SHIFT_BITS   = PROD_BITS - FRAC_BITS;

    typedef logic signed [WORD_BITS-1:0] t_word;

    localparam t_word WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // Register values after reset.
    localparam t_word               COEF_SQUARE_RST   = t_word'(49152);
    localparam t_word               COEF_LINEAR_RST   = t_word'(-277545);
    localparam t_word               COEF_CONSTANT_RST = t_word'(203948);
    localparam logic [TOL_BITS-1:0] TOLERANCE_RST     = TOL_BITS'(7);
    localparam logic [CNT_BITS-1:0] ITER_LIMIT_RST    = CNT_BITS'(100);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_COEF_SQUARE     = 3'd0,
        CFG_COEF_LINEAR     = 3'd1,
        CFG_COEF_CONSTANT   = 3'd2,
        CFG_TOLERANCE       = 3'd3,
        CFG_ITERATION_LIMIT = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_CONVERGED = 2'd0,
        ST_LIMIT     = 2'd1,
        ST_NO_ROOT   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POLY,
        S_CHECK,
        S_MIDPT,
        S_DECIDE,
        S_OUTPUT
    } t_state;

    // Which point the current polynomial evaluation belongs to.
    typedef enum logic [1:0] {
        PH_LO,
        PH_HI,
        PH_MID
    } t_phase;

    typedef enum logic [1:0] {
        MS_AX,
        MS_BX,
        MS_TX
    } t_mul_sel;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_T1,
        RD_T3,
        RD_T2
    } t_rnd_dst;

    typedef enum logic [1:0] {
        FD_NONE,
        FD_LO,
        FD_HI,
        FD_M
    } t_f_dst;

    // Steps of one polynomial evaluation on the shared multiplier.
    localparam logic [STEP_BITS-1:0] STEP_AX   = 3'd0;
    localparam logic [STEP_BITS-1:0] STEP_BX   = 3'd1;
    localparam logic [STEP_BITS-1:0] STEP_TX   = 3'd2;
    localparam logic [STEP_BITS-1:0] STEP_SQ   = 3'd3;
    localparam logic [STEP_BITS-1:0] STEP_SUM  = 3'd4;
    localparam logic [STEP_BITS-1:0] STEP_FVAL = 3'd5;

    typedef struct packed {
        logic     load_in;
        logic     x_hi;
        logic     mid;
        t_mul_sel mul_sel;
        t_rnd_dst rnd_dst;
        logic     sum_en;
        t_f_dst   f_dst;
        logic     no_root;
        logic     decide;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic root_bracketed;
        logic converged;
        logic limit_hit;
    } t_dp_stat;

endpackage

/* src/bisection_root_finder.sv */
// Top level of the bisection root finder for f(x) = A*x*x + B*x + C in Q16.16.
// Depends on brf_pkg, brf_ctrl, brf_datapath (which holds brf_mul).
//
//   Channel   Handshake                      Payload
//   input     i_in_valid / o_in_stall        i_interval_low, i_interval_high
//   output    o_out_valid / i_out_stall      o_root_estimate, o_value_at_root,
//                                            o_iterations_used, o_status
//   config    i_cfg_we (no wait)             i_cfg_index, i_cfg_data
//
// From acceptance until its result is loaded, an item runs the evaluations at
// both ends, then one midpoint, evaluation and decision per bisection iteration
// (1 to 127 iterations); an interval without a sign change skips the iterations.
// The schedule is set by the single shared multiplier: each polynomial evaluation
// is three multiplies scheduled over the AX, BX, TX, SQ, SUM and FVAL steps.
// Reset is synchronous and active low; it restores the coefficient, tolerance
// and limit registers to their defaults and empties the output register.
// While the output register holds an unaccepted item a new item may still be
// accepted; its result waits in the datapath registers until the output
// register frees.
module bisection_root_finder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input channel.
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [31:0]               i_interval_low,
    input  logic signed [31:0]               i_interval_high,
    // Output channel.
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [31:0]               o_root_estimate,
    output logic signed [31:0]               o_value_at_root,
    output logic [6:0]                       o_iterations_used,
    output logic [1:0]                       o_status,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [brf_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [31:0]                      i_cfg_data
);

    // Commands from the controller and status flags back from the datapath
    // are the only link between the two halves.
    brf_pkg::t_dp_cmd  cmd;
    brf_pkg::t_dp_stat stat;

    brf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // The datapath holds the interval, the function values at its ends and
    // at the midpoint, the iteration counter and the output register.
    brf_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_interval_low    (i_interval_low),
        .i_interval_high   (i_interval_high),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_root_estimate   (o_root_estimate),
        .o_value_at_root   (o_value_at_root),
        .o_iterations_used (o_iterations_used),
        .o_status          (o_status)
    );

endmodule

/* src/brf_mul.sv */
// Shared signed fixed-point multiplier: registered magnitude product, then
// rounding to nearest (ties away from zero) and saturation. Uses brf_pkg.
module brf_mul (
    input  logic           i_clk,
    input  brf_pkg::t_word i_a,
    input  brf_pkg::t_word i_b,
    output brf_pkg::t_word o_result
);

    localparam logic [brf_pkg::PROD_BITS-1:0] ROUND_HALF =
        brf_pkg::PROD_BITS'(1) << (brf_pkg::FRAC_BITS - 1);

    logic [brf_pkg::WORD_BITS-1:0]  mag_a;
    logic [brf_pkg::WORD_BITS-1:0]  mag_b;
    logic [brf_pkg::PROD_BITS-1:0]  r_prod;
    logic                           r_neg;
    logic [brf_pkg::PROD_BITS-1:0]  rounded;
    logic [brf_pkg::SHIFT_BITS-1:0] shifted;
    logic                           over;

    assign mag_a = i_a[brf_pkg::WORD_BITS-1] ? (~i_a + 1'b1) : i_a;
    assign mag_b = i_b[brf_pkg::WORD_BITS-1] ? (~i_b + 1'b1) : i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= brf_pkg::PROD_BITS'(mag_a) * brf_pkg::PROD_BITS'(mag_b);
        r_neg  <= i_a[brf_pkg::WORD_BITS-1] ^ i_b[brf_pkg::WORD_BITS-1];
    end

    assign rounded = r_prod + ROUND_HALF;
    assign shifted = rounded[brf_pkg::PROD_BITS-1:brf_pkg::FRAC_BITS];
    // A magnitude of 2^(W-1) or more saturates; for a negative result that
    // bound is exactly the most negative word, so one test serves both signs.
    assign over    = |shifted[brf_pkg::SHIFT_BITS-1:brf_pkg::WORD_BITS-1];

    always_comb begin
        if (over) begin
            o_result = r_neg ? brf_pkg::WORD_MIN : brf_pkg::WORD_MAX;
        end else if (r_neg) begin
            o_result = -$signed(shifted[brf_pkg::WORD_BITS-1:0]);
        end else begin
            o_result = $signed(shifted[brf_pkg::WORD_BITS-1:0]);
        end
    end

endmodule

/* src/brf_datapath.sv */
// Datapath of the root finder: configuration registers, interval and
// function-value registers, polynomial evaluation, result registers.
// Uses brf_pkg and brf_mul.
module brf_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [brf_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [brf_pkg::WORD_BITS-1:0]    i_cfg_data,
    input  brf_pkg::t_word                   i_interval_low,
    input  brf_pkg::t_word                   i_interval_high,
    input  brf_pkg::t_dp_cmd                 i_cmd,
    output brf_pkg::t_dp_stat                o_stat,
    output brf_pkg::t_word                   o_root_estimate,
    output brf_pkg::t_word                   o_value_at_root,
    output logic [brf_pkg::CNT_BITS-1:0]     o_iterations_used,
    output logic [1:0]                       o_status
);

    function automatic brf_pkg::t_word sat_add(input brf_pkg::t_word a,
                                               input brf_pkg::t_word b);
        logic signed [brf_pkg::WORD_BITS:0] s;
        s = $signed({a[brf_pkg::WORD_BITS-1], a}) + $signed({b[brf_pkg::WORD_BITS-1], b});
        if (s[brf_pkg::WORD_BITS] != s[brf_pkg::WORD_BITS-1]) begin
            sat_add = s[brf_pkg::WORD_BITS] ? brf_pkg::WORD_MIN : brf_pkg::WORD_MAX;
        end else begin
            sat_add = s[brf_pkg::WORD_BITS-1:0];
        end
    endfunction

    // True when the two values have a product of zero or less.
    function automatic logic straddles(input brf_pkg::t_word a, input brf_pkg::t_word b);
        straddles = (a == '0) || (b == '0) ||
                    (a[brf_pkg::WORD_BITS-1] != b[brf_pkg::WORD_BITS-1]);
    endfunction

    brf_pkg::t_word                   r_coef_sq;
    brf_pkg::t_word                   r_coef_lin;
    brf_pkg::t_word                   r_coef_const;
    logic [brf_pkg::TOL_BITS-1:0]     r_tol;
    logic [brf_pkg::CNT_BITS-1:0]     r_limit;
    brf_pkg::t_word                   r_lo;
    brf_pkg::t_word                   r_hi;
    brf_pkg::t_word                   r_m;
    brf_pkg::t_word                   r_x;
    brf_pkg::t_word                   r_t1;
    brf_pkg::t_word                   r_t2;
    brf_pkg::t_word                   r_t3;
    brf_pkg::t_word                   r_s;
    brf_pkg::t_word                   r_flo;
    brf_pkg::t_word                   r_fhi;
    brf_pkg::t_word                   r_fm;
    logic [brf_pkg::CNT_BITS-1:0]     r_cnt;
    brf_pkg::t_status                 r_res_status;
    brf_pkg::t_word                   r_out_root;
    brf_pkg::t_word                   r_out_value;
    logic [brf_pkg::CNT_BITS-1:0]     r_out_cnt;
    brf_pkg::t_status                 r_out_status;

    brf_pkg::t_word                   mul_a;
    brf_pkg::t_word                   mul_res;
    brf_pkg::t_word                   fval;
    logic signed [brf_pkg::WORD_BITS:0] mid_sum;
    brf_pkg::t_word                   mid;
    logic [brf_pkg::WORD_BITS-1:0]    fm_mag;
    logic [brf_pkg::CNT_BITS:0]       cnt_inc;

    always_comb begin
        case (i_cmd.mul_sel)
            brf_pkg::MS_AX: mul_a = r_coef_sq;
            brf_pkg::MS_BX: mul_a = r_coef_lin;
            brf_pkg::MS_TX: mul_a = r_t1;
            default:        mul_a = r_coef_sq;
        endcase
    end

    brf_mul u_mul (
        .i_clk    (i_clk),
        .i_a      (mul_a),
        .i_b      (r_x),
        .o_result (mul_res)
    );

    assign fval    = sat_add(r_s, r_coef_const);
    assign mid_sum = $signed({r_lo[brf_pkg::WORD_BITS-1], r_lo}) +
                     $signed({r_hi[brf_pkg::WORD_BITS-1], r_hi});
    assign mid     = mid_sum[brf_pkg::WORD_BITS:1];
    assign fm_mag  = r_fm[brf_pkg::WORD_BITS-1] ? (~r_fm + 1'b1) : r_fm;
    assign cnt_inc = {1'b0, r_cnt} + 1'b1;

    assign o_stat.root_bracketed = straddles(r_flo, r_fhi);
    assign o_stat.converged      = fm_mag <= brf_pkg::WORD_BITS'(r_tol);
    assign o_stat.limit_hit      = cnt_inc >= {1'b0, r_limit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_sq    <= brf_pkg::COEF_SQUARE_RST;
            r_coef_lin   <= brf_pkg::COEF_LINEAR_RST;
            r_coef_const <= brf_pkg::COEF_CONSTANT_RST;
            r_tol        <= brf_pkg::TOLERANCE_RST;
            r_limit      <= brf_pkg::ITER_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (brf_pkg::t_cfg_idx'(i_cfg_index))
                brf_pkg::CFG_COEF_SQUARE:     r_coef_sq    <= i_cfg_data;
                brf_pkg::CFG_COEF_LINEAR:     r_coef_lin   <= i_cfg_data;
                brf_pkg::CFG_COEF_CONSTANT:   r_coef_const <= i_cfg_data;
                brf_pkg::CFG_TOLERANCE:       r_tol        <= i_cfg_data[brf_pkg::TOL_BITS-1:0];
                brf_pkg::CFG_ITERATION_LIMIT: r_limit      <= i_cfg_data[brf_pkg::CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load_in || i_cmd.no_root) begin
            r_cnt <= '0;
        end else if (i_cmd.decide && !o_stat.converged) begin
            r_cnt <= cnt_inc[brf_pkg::CNT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_lo <= i_interval_low;
            r_hi <= i_interval_high;
            r_x  <= i_interval_low;
        end
        if (i_cmd.x_hi) begin
            r_x <= r_hi;
        end
        if (i_cmd.mid) begin
            r_m <= mid;
            r_x <= mid;
        end

        case (i_cmd.rnd_dst)
            brf_pkg::RD_T1: r_t1 <= mul_res;
            brf_pkg::RD_T3: r_t3 <= mul_res;
            brf_pkg::RD_T2: r_t2 <= mul_res;
            default: ;
        endcase

        if (i_cmd.sum_en) begin
            r_s <= sat_add(r_t2, r_t3);
        end

        case (i_cmd.f_dst)
            brf_pkg::FD_LO: r_flo <= fval;
            brf_pkg::FD_HI: r_fhi <= fval;
            brf_pkg::FD_M:  r_fm  <= fval;
            default: ;
        endcase

        if (i_cmd.no_root) begin
            r_m          <= '0;
            r_fm         <= '0;
            r_res_status <= brf_pkg::ST_NO_ROOT;
        end

        // Keep the half whose ends straddle zero; f(lo) follows lo.
        if (i_cmd.decide) begin
            if (straddles(r_flo, r_fm)) begin
                r_hi <= r_m;
            end else begin
                r_lo  <= r_m;
                r_flo <= r_fm;
            end
            r_res_status <= o_stat.converged ? brf_pkg::ST_CONVERGED : brf_pkg::ST_LIMIT;
        end

        if (i_cmd.out_load) begin
            r_out_root   <= r_m;
            r_out_value  <= r_fm;
            r_out_cnt    <= r_cnt;
            r_out_status <= r_res_status;
        end
    end

    assign o_root_estimate   = r_out_root;
    assign o_value_at_root   = r_out_value;
    assign o_iterations_used = r_out_cnt;
    assign o_status          = r_out_status;

endmodule

/* src/brf_ctrl.sv */
// Controller of the root finder: sequences the endpoint evaluations, the
// bisection iterations and the result handshake. Uses brf_pkg.
module brf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_stall,
    input  brf_pkg::t_dp_stat i_stat,
    output brf_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall,
    output logic              o_out_valid
);

    brf_pkg::t_state                 r_state;
    brf_pkg::t_state                 n_state;
    brf_pkg::t_phase                 r_phase;
    brf_pkg::t_phase                 n_phase;
    logic [brf_pkg::STEP_BITS-1:0]   r_step;
    logic [brf_pkg::STEP_BITS-1:0]   n_step;
    logic                            r_out_valid;
    logic                            n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brf_pkg::S_IDLE;
            r_phase     <= brf_pkg::PH_LO;
            r_step      <= brf_pkg::STEP_AX;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_step      = r_step;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;

        case (r_state)
            brf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_phase       = brf_pkg::PH_LO;
                    n_step        = brf_pkg::STEP_AX;
                    n_state       = brf_pkg::S_POLY;
                end
            end

            brf_pkg::S_POLY: begin
                n_step = r_step + 1'b1;
                case (r_step)
                    brf_pkg::STEP_AX: begin
                        o_cmd.mul_sel = brf_pkg::MS_AX;
                    end
                    brf_pkg::STEP_BX: begin
                        o_cmd.mul_sel = brf_pkg::MS_BX;
                        o_cmd.rnd_dst = brf_pkg::RD_T1;
                    end
                    brf_pkg::STEP_TX: begin
                        o_cmd.mul_sel = brf_pkg::MS_TX;
                        o_cmd.rnd_dst = brf_pkg::RD_T3;
                    end
                    brf_pkg::STEP_SQ: begin
                        o_cmd.rnd_dst = brf_pkg::RD_T2;
                    end
                    brf_pkg::STEP_SUM: begin
                        o_cmd.sum_en = 1'b1;
                    end
                    brf_pkg::STEP_FVAL: begin
                        n_step = brf_pkg::STEP_AX;
                        case (r_phase)
                            brf_pkg::PH_LO: begin
                                o_cmd.f_dst = brf_pkg::FD_LO;
                                o_cmd.x_hi  = 1'b1;
                                n_phase     = brf_pkg::PH_HI;
                            end
                            brf_pkg::PH_HI: begin
                                o_cmd.f_dst = brf_pkg::FD_HI;
                                n_state     = brf_pkg::S_CHECK;
                            end
                            brf_pkg::PH_MID: begin
                                o_cmd.f_dst = brf_pkg::FD_M;
                                n_state     = brf_pkg::S_DECIDE;
                            end
                            default: begin
                                n_state = brf_pkg::S_IDLE;
                            end
                        endcase
                    end
                    default: begin
                        n_step = brf_pkg::STEP_AX;
                    end
                endcase
            end

            brf_pkg::S_CHECK: begin
                if (i_stat.root_bracketed) begin
                    n_state = brf_pkg::S_MIDPT;
                end else begin
                    o_cmd.no_root = 1'b1;
                    n_state       = brf_pkg::S_OUTPUT;
                end
            end

            brf_pkg::S_MIDPT: begin
                o_cmd.mid = 1'b1;
                n_phase   = brf_pkg::PH_MID;
                n_step    = brf_pkg::STEP_AX;
                n_state   = brf_pkg::S_POLY;
            end

            brf_pkg::S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_stat.converged || i_stat.limit_hit) begin
                    n_state = brf_pkg::S_OUTPUT;
                end else begin
                    n_state = brf_pkg::S_MIDPT;
                end
            end

            brf_pkg::S_OUTPUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = brf_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = brf_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != brf_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* src/brf_checker.sv */
// Port-level checks of the bisection root finder, bound to the top level.
// Depends on brf_pkg and bisection_root_finder.
module brf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_root_estimate,
    input logic signed [31:0] o_value_at_root,
    input logic [6:0]         o_iterations_used,
    input logic [1:0]         o_status
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled result does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_root_estimate) &&
            $stable(o_value_at_root) && $stable(o_iterations_used) && $stable(o_status))
        else $error("output item changed while stalled");

    // Acceptance moves the controller out of the idle state, so the input closes after acceptance.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken on two consecutive cycles");

    // An interval without a sign change reports a zero root, value and iteration count.
    a_no_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == brf_pkg::ST_NO_ROOT) |->
            (o_root_estimate == '0) && (o_value_at_root == '0) &&
            (o_iterations_used == '0))
        else $error("no-root item carries nonzero fields");

endmodule

bind bisection_root_finder brf_checker u_brf_checker (.*);

/* tb/sv/tb.sv */
// Self-checking testbench for bisection_root_finder: drives intervals under random idling.
// It predicts every result with its own fixed-point model of the search and checks each field.
// Depends on brf_pkg and the bisection_root_finder RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brf_pkg::*;

    localparam int    ITEM_TARGET   = 1750;
    localparam int    CYCLE_LIMIT   = 10_000_000;
    // Covers the longest search, of 127 iterations.
    localparam int    SETTLE_CYCLES = 14 + 8 * 127 + 32;
    localparam int    IDLE_PCT      = 19;
    localparam t_word Q_ONE         = t_word'(1 << FRAC_BITS);

    // One expected result of the search.
    typedef struct packed {
        t_word               root;
        t_word               fval;
        logic [CNT_BITS-1:0] iters;
        t_status             status;
    } t_search_result;

    // Clock, reset and every block input start at known values.
    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_in_valid      = 1'b0;
    logic signed [31:0]      i_interval_low  = '0;
    logic signed [31:0]      i_interval_high = '0;
    logic                    i_out_stall     = 1'b0;
    logic                    i_cfg_we        = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index     = '0;
    logic [31:0]             i_cfg_data      = '0;

    logic                    o_in_stall;
    logic                    o_out_valid;
    logic signed [31:0]      o_root_estimate;
    logic signed [31:0]      o_value_at_root;
    logic [6:0]              o_iterations_used;
    logic [1:0]              o_status;

    // Our copy of the configuration registers, starting at their reset values.
    t_word                   sq_coef    = COEF_SQUARE_RST;
    t_word                   lin_coef   = COEF_LINEAR_RST;
    t_word                   const_coef = COEF_CONSTANT_RST;
    logic [TOL_BITS-1:0]     tol_bound  = TOLERANCE_RST;
    logic [CNT_BITS-1:0]     iter_cap   = ITER_LIMIT_RST;

    t_search_result          pending_results[$];
    t_search_result          head;
    int                      items_sent      = 0;
    int                      results_checked = 0;
    int                      fail_count      = 0;
    int                      cycle_count     = 0;
    // When set, neither side idles: the block sees a continuous stream.
    bit                      steady_flow     = 1'b0;

    bisection_root_finder dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_interval_low    (i_interval_low),
        .i_interval_high   (i_interval_high),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_root_estimate   (o_root_estimate),
        .o_value_at_root   (o_value_at_root),
        .o_iterations_used (o_iterations_used),
        .o_status          (o_status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Fixed-point arithmetic of the search, Q16.16 in a 32-bit word.
    // ------------------------------------------------------------------

    // Product shifted down by the fraction bits, magnitude rounded to nearest
    // with ties away from zero, then saturated to the word range.
    function automatic t_word q_mul(input t_word a, input t_word b);
        logic signed [PROD_BITS-1:0] prod;
        logic [PROD_BITS-1:0]        mag;
        logic [PROD_BITS-1:0]        rounded;
        prod    = PROD_BITS'(a) * PROD_BITS'(b);
        mag     = prod[PROD_BITS-1] ? -prod : prod;
        rounded = (mag + (PROD_BITS'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (!prod[PROD_BITS-1])
            return (rounded > PROD_BITS'(WORD_MAX)) ? WORD_MAX : t_word'(rounded);
        return (rounded > PROD_BITS'(WORD_MAX) + 1) ? WORD_MIN : t_word'(-rounded);
    endfunction

    function automatic t_word q_add(input t_word a, input t_word b);
        logic signed [WORD_BITS:0] sum;
        sum = a + b;
        if (sum > WORD_MAX) return WORD_MAX;
        if (sum < WORD_MIN) return WORD_MIN;
        return t_word'(sum);
    endfunction

    // f(x) = A*x*x + B*x + C with every step saturating, in the block's order.
    function automatic t_word quad_value(input t_word x);
        return q_add(q_add(q_mul(q_mul(sq_coef, x), x), q_mul(lin_coef, x)), const_coef);
    endfunction

    // True when the product of the two values is zero or negative.
    function automatic bit sign_change(input t_word fp, input t_word fq);
        return fp == 0 || fq == 0 || (fp[WORD_BITS-1] != fq[WORD_BITS-1]);
    endfunction

    // Floor of the mean, computed one bit wider so it never overflows.
    function automatic t_word mid_floor(input t_word a, input t_word b);
        logic signed [WORD_BITS:0] sum;
        sum = a + b;
        return t_word'(sum >>> 1);
    endfunction

    // The whole bisection for one interval under the current settings.
    function automatic t_search_result run_search(input t_word lo, input t_word hi);
        t_search_result res;
        t_word          m;
        t_word          fm;
        logic [WORD_BITS:0] fm_mag;
        int             count;
        res.root   = '0;
        res.fval   = '0;
        res.iters  = '0;
        res.status = ST_NO_ROOT;
        if (!sign_change(quad_value(lo), quad_value(hi)))
            return res;
        count = 0;
        m     = '0;
        fm    = '0;
        while (1) begin
            m  = mid_floor(lo, hi);
            fm = quad_value(m);
            if (sign_change(quad_value(lo), fm))
                hi = m;
            else
                lo = m;
            fm_mag = fm[WORD_BITS-1] ? -{fm[WORD_BITS-1], fm} : {1'b0, fm};
            // The tolerance test comes before the counter moves, so a search
            // that converges on its last allowed pass still reports converged.
            if (fm_mag <= {2'b00, tol_bound}) begin
                res.status = ST_CONVERGED;
                break;
            end
            count++;
            if (count >= iter_cap) begin
                res.status = ST_LIMIT;
                break;
            end
        end
        res.root  = m;
        res.fval  = fm;
        res.iters = CNT_BITS'(count);
        return res;
    endfunction

    // Signed random value whose magnitude stays at or below 2**(bits-1).
    function automatic t_word rand_signed(input int bits);
        return t_word'($signed($urandom) >>> (WORD_BITS - bits));
    endfunction

    // Random non-negative distance from a known root, from zero up to 2**27 - 1.
    function automatic t_word rand_reach();
        return t_word'($urandom_range(32'h7FFF_FFFF) >> $urandom_range(31, 4));
    endfunction

    // ------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fail_count++;
        $display("%0t: result %0d: %s is %0d, expected %0d",
                 $realtime, results_checked, what, got, want);
    endtask

    // Each result accepted at this edge is compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no interval pending", 1, 0);
            end else begin
                head = pending_results.pop_front();
                if (o_root_estimate !== head.root)
                    report_mismatch("root_estimate", o_root_estimate, head.root);
                if (o_value_at_root !== head.fval)
                    report_mismatch("value_at_root", o_value_at_root, head.fval);
                if (o_iterations_used !== head.iters)
                    report_mismatch("iterations_used", o_iterations_used, head.iters);
                if (o_status !== head.status)
                    report_mismatch("status", o_status, head.status);
            end
            results_checked++;
        end
    end

    // The result side holds off at random unless the stream is meant to be steady.
    always @(posedge i_clk) begin
        i_out_stall <= !steady_flow && ($urandom_range(99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------

    // Offers one interval and returns at the edge that accepts it. Valid is
    // left high so that a following item can go out without a gap; whoever
    // stops sending lowers it.
    task automatic send_interval(input t_word lo, input t_word hi);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_interval_low  <= lo;
        i_interval_high <= hi;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pending_results.push_back(run_search(lo, hi));
        items_sent++;
    endtask

    // Stops sending and waits until every predicted result has come back.
    // Every item produces a result, so an empty queue means the block is idle.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Writes all five registers back to back while the block is idle, then
    // hits an index past the last register, which must change nothing. The
    // spare upper data bits of the narrow registers carry random values.
    task automatic load_settings(input t_word sq, input t_word lin, input t_word cst,
                                 input logic [TOL_BITS-1:0] tol,
                                 input logic [CNT_BITS-1:0] lim);
        logic [31:0] word;
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_COEF_SQUARE;
        i_cfg_data  <= sq;
        @(posedge i_clk);
        i_cfg_index <= CFG_COEF_LINEAR;
        i_cfg_data  <= lin;
        @(posedge i_clk);
        i_cfg_index <= CFG_COEF_CONSTANT;
        i_cfg_data  <= cst;
        @(posedge i_clk);
        word = $urandom;
        word[TOL_BITS-1:0] = tol;
        i_cfg_index <= CFG_TOLERANCE;
        i_cfg_data  <= word;
        @(posedge i_clk);
        word = $urandom;
        word[CNT_BITS-1:0] = lim;
        i_cfg_index <= CFG_ITERATION_LIMIT;
        i_cfg_data  <= word;
        @(posedge i_clk);
        i_cfg_index <= CFG_IDX_BITS'($urandom_range((1 << CFG_IDX_BITS) - 1,
                                                    int'(CFG_ITERATION_LIMIT) + 1));
        i_cfg_data  <= $urandom;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sq_coef    = sq;
        lin_coef   = lin;
        const_coef = cst;
        tol_bound  = tol;
        iter_cap   = lim;
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset values: 0.75x^2 - 4.235x + 3.112 has roots near 0.868 and 4.778.
    task automatic test_default_coefficients();
        send_interval('0, 2 * Q_ONE);
        // Same bracket with the endpoints swapped.
        send_interval(2 * Q_ONE, '0);
        // Both roots inside, so the ends share a sign and there is no root.
        send_interval('0, 10 * Q_ONE);
        send_interval(WORD_MIN, WORD_MAX);
        send_interval(3 * Q_ONE, 6 * Q_ONE);
    endtask

    // f(x) = x: an endpoint at an exact zero, and the extreme iteration limits.
    task automatic test_zero_endpoint_and_limits();
        // A limit of zero still runs one pass.
        load_settings('0, Q_ONE, '0, '0, '0);
        send_interval('0, 100 * Q_ONE);
        send_interval(-1, 1);
        load_settings('0, Q_ONE, '0, '0, '1);
        send_interval('0, 100 * Q_ONE);
        send_interval(WORD_MIN, WORD_MAX);
        send_interval(1, -1);
    endtask

    // f(x) = 0.5x rounds single LSBs away from zero; the widest tolerance
    // makes the first pass converge, which is also the pass that hits a limit of one.
    task automatic test_rounding_and_tolerance();
        load_settings('0, Q_ONE / 2, '0, '1, CNT_BITS'(1));
        send_interval(-1, 1);
        send_interval(-3, 5);
        send_interval(7, 9);
    endtask

    // Coefficients at the ends of the word drive the multiplies and adds into saturation.
    task automatic test_saturation();
        load_settings(WORD_MIN, WORD_MAX, WORD_MIN, '0, CNT_BITS'(3));
        send_interval(WORD_MIN, WORD_MAX);
        send_interval(WORD_MAX, WORD_MIN);
        send_interval('0, 1);
        send_interval(-1, '0);
        load_settings(WORD_MAX, WORD_MIN, WORD_MAX, TOL_BITS'(1), '1);
        send_interval('0, WORD_MAX);
        send_interval(WORD_MIN, -1);
    endtask

    // A long run with no idling on either side, bracketing the lower default root.
    task automatic test_back_to_back();
        t_word lo;
        t_word hi;
        t_word tmp;
        steady_flow = 1'b1;
        load_settings(COEF_SQUARE_RST, COEF_LINEAR_RST, COEF_CONSTANT_RST,
                      TOLERANCE_RST, ITER_LIMIT_RST);
        repeat (60) begin
            // Below the root near 0.868, and between it and the root near 4.778.
            lo = t_word'($urandom_range(56000));
            hi = t_word'($urandom_range(4 * Q_ONE, 57000));
            if ($urandom_range(1)) begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
            send_interval(lo, hi);
        end
        steady_flow = 1'b0;
    endtask

    // Batches of items under random settings. Most batches build the constant
    // so that f has an exact zero at a chosen point and then bracket that point,
    // so the search runs deep; a fifth of the items are raw random intervals.
    // Some batches use fully random coefficients, and a few use the largest limit.
    task automatic test_random_search();
        t_word               a;
        t_word               b;
        t_word               c;
        t_word               x0;
        t_word               part;
        t_word               lo;
        t_word               hi;
        t_word               tmp;
        logic [TOL_BITS-1:0] tol;
        logic [CNT_BITS-1:0] lim;
        int                  n;
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(7) == 0) begin
                a  = t_word'($urandom);
                b  = t_word'($urandom);
                c  = t_word'($urandom);
                x0 = t_word'($urandom);
            end else begin
                a    = rand_signed($urandom_range(22, 2));
                b    = rand_signed($urandom_range(28, 2));
                x0   = rand_signed($urandom_range(26, 2));
                part = q_add(q_mul(q_mul(a, x0), x0), q_mul(b, x0));
                c    = (part == WORD_MIN) ? WORD_MAX : -part;
            end
            case ($urandom_range(3))
                0: tol = '0;
                1: tol = TOL_BITS'($urandom_range(64));
                default: tol = TOL_BITS'($urandom) >> $urandom_range(TOL_BITS - 1);
            endcase
            if ($urandom_range(7) == 0) begin
                lim = '1;
                n   = 5;
            end else begin
                lim = CNT_BITS'($urandom_range(30, 1));
                n   = $urandom_range(40, 15);
            end
            load_settings(a, b, c, tol, lim);
            repeat (n) begin
                if ($urandom_range(99) < 20) begin
                    lo = t_word'($urandom);
                    hi = t_word'($urandom);
                end else begin
                    lo = q_add(x0, -rand_reach());
                    hi = q_add(x0, rand_reach());
                    if ($urandom_range(1)) begin
                        tmp = lo;
                        lo  = hi;
                        hi  = tmp;
                    end
                end
                send_interval(lo, hi);
            end
        end
    endtask

    // Ends the run as failed once the cycle limit is reached, which catches a block that stops making progress.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_coefficients();
        test_zero_endpoint_and_limits();
        test_rounding_and_tolerance();
        test_saturation();
        test_back_to_back();
        test_random_search();
        drain();
        // Any result beyond the last prediction would show up in this window.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never produced", pending_results.size(), 0);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
src/brf_pkg.sv
src/brf_mul.sv
src/brf_datapath.sv
src/brf_ctrl.sv
src/bisection_root_finder.sv
src/brf_checker.sv
tb/sv/tb.sv
